/* rtl/core/bsnf_pkg.sv */
// Shared types and constants of the binary speckle noise filter.
// Used by every module in rtl/core; depends on nothing.
`default_nettype none

package bsnf_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int WIN_ROWS     = 4;
  localparam int WIN_COLS     = 5;
  localparam int DRAIN_STEPS  = WIN_COLS;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WID_W        = 11;
  localparam int HGT_W        = 13;
  localparam int PIX_W        = 8;
  localparam int SLOT_W       = $clog2(WIN_ROWS);
  localparam int WORD_W       = WIN_ROWS * PIX_W;
  localparam int DRAIN_W      = $clog2(DRAIN_STEPS + 1);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_CHAR   = 3'd2,
    REG_BACK   = 3'd3,
    REG_STRICT = 3'd4
  } cfg_reg_e;

  // one classified input word, rows of the window are r-3 .. r
  typedef struct packed {
    logic [PIX_W-1:0]    pix;
    logic [COL_W-1:0]    col;
    logic [SLOT_W-1:0]   slot;
    logic [WIN_ROWS-1:0] rin;
    logic                judge_row;
    logic                last_row;
    logic                row_end;
  } entry_t;

  typedef struct packed {
    logic ctr;
    logic right;
    logic down_left;
    logic down;
  } clr_t;

endpackage

`default_nettype wire

/* rtl/core/bsnf_front.sv */
// Front end: raster counters and classification of each accepted word.
// Depends on bsnf_pkg.
`default_nettype none

module bsnf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic                          accept_i,
  input  logic                          op_i,
  input  logic [bsnf_pkg::PIX_W-1:0]    pixel_value_i,
  input  logic [bsnf_pkg::WID_W-1:0]    width_i,
  input  logic [bsnf_pkg::HGT_W-1:0]    height_i,
  input  logic [bsnf_pkg::PIX_W-1:0]    back_i,
  output bsnf_pkg::entry_t              entry_o
);
  import bsnf_pkg::*;

  logic [HGT_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [HGT_W:0]   r_x, h_x;
  logic [COL_W-1:0] last_col;
  logic             done;

  always_comb begin
    if (width_i == '0) begin
      w_eff = WID_W'(1);
    end else if (width_i > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = width_i;
    end
    if (height_i == '0) begin
      h_eff = HGT_W'(1);
    end else if (height_i > HGT_W'(HEIGHT_LIMIT)) begin
      h_eff = HGT_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = height_i;
    end
  end

  assign last_col = COL_W'(w_eff - WID_W'(1));
  assign r_x      = {1'b0, row_q};
  assign h_x      = {1'b0, h_eff};

  always_comb begin
    entry_o.rin[3]    = r_x < h_x;
    entry_o.rin[2]    = (r_x >= (HGT_W+1)'(1)) && (r_x <= h_x);
    entry_o.rin[1]    = r_x >= (HGT_W+1)'(2);
    entry_o.rin[0]    = r_x >= (HGT_W+1)'(3);
    entry_o.judge_row = r_x >= (HGT_W+1)'(2);
    entry_o.last_row  = r_x == (h_x + (HGT_W+1)'(1));
    entry_o.row_end   = col_q == last_col;
    entry_o.col       = col_q;
    entry_o.slot      = row_q[SLOT_W-1:0];
    // padding rows and flush words enter as background
    entry_o.pix       = (entry_o.rin[3] && !op_i) ? pixel_value_i : back_i;
  end

  assign done = entry_o.last_row && entry_o.row_end;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (restart_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept_i) begin
      if (done) begin
        row_d = '0;
        col_d = '0;
      end else if (entry_o.row_end) begin
        row_d = row_q + HGT_W'(1);
        col_d = '0;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bsnf_queue.sv */
// Short queue of classified words between front and back end.
// Depends on bsnf_pkg.
`default_nettype none

module bsnf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              flush_i,
  input  logic              push_i,
  input  bsnf_pkg::entry_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output bsnf_pkg::entry_t  head_o
);
  import bsnf_pkg::*;

  entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else if (flush_i) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bsnf_judge.sv */
// Window tests for one center pixel: decides which pixels get cleared.
// Depends on bsnf_pkg; ch_i[x][y] is column j-2+x, row i-1+y.
`default_nettype none

module bsnf_judge (
  input  logic [4:0][3:0] ch_i,
  input  logic            strict_i,
  output bsnf_pkg::clr_t  clr_o
);
  import bsnf_pkg::*;

  logic [3:0]  diag, four;
  logic [2:0]  nd;
  logic [3:0]  n1;
  logic [9:0]  t1, t2, t3;
  logic [11:0] ra, rb;
  logic        ring_ok, strict_ok, cluster;

  assign diag = {ch_i[1][0], ch_i[3][0], ch_i[3][2], ch_i[1][2]};
  assign four = {ch_i[2][0], ch_i[1][1], ch_i[2][2], ch_i[3][1]};
  assign nd   = 3'($countones(diag));
  assign n1   = 4'(nd) + 4'($countones(four));

  assign t1 = {ch_i[0][0], ch_i[1][0], ch_i[2][0], ch_i[3][0],
               ch_i[0][2], ch_i[1][2], ch_i[2][2], ch_i[3][2], ch_i[0][1], ch_i[3][1]};
  assign t2 = {ch_i[1][0], ch_i[1][1], ch_i[1][2], ch_i[1][3],
               ch_i[3][0], ch_i[3][1], ch_i[3][2], ch_i[3][3], ch_i[2][0], ch_i[2][3]};
  assign t3 = {ch_i[1][0], ch_i[2][0], ch_i[3][0], ch_i[4][0],
               ch_i[1][2], ch_i[2][2], ch_i[3][2], ch_i[4][2], ch_i[1][1], ch_i[4][1]};
  // 4x4 rings shifted right and left of the center
  assign ra = {ch_i[1][0], ch_i[2][0], ch_i[3][0], ch_i[4][0],
               ch_i[1][3], ch_i[2][3], ch_i[3][3], ch_i[4][3],
               ch_i[1][1], ch_i[1][2], ch_i[4][1], ch_i[4][2]};
  assign rb = {ch_i[0][0], ch_i[1][0], ch_i[2][0], ch_i[3][0],
               ch_i[0][3], ch_i[1][3], ch_i[2][3], ch_i[3][3],
               ch_i[0][1], ch_i[0][2], ch_i[3][1], ch_i[3][2]};

  assign ring_ok   = ($countones(ra) <= 1) && ($countones(rb) <= 1);
  assign strict_ok = ($countones(t1) <= 1) && ($countones(t2) <= 1) &&
                     ($countones(t3) <= 1);

  always_comb begin
    clr_o   = '0;
    cluster = 1'b0;
    if (ch_i[2][1] && nd <= 3'd2) begin
      if (nd < 3'd2) begin
        if (n1 == '0) begin
          clr_o.ctr = 1'b1;
        end else if (n1 == 4'd1 && strict_i) begin
          cluster = strict_ok && ring_ok;
        end
      end else begin
        cluster = ring_ok;
      end
    end
    if (cluster) begin
      clr_o.ctr = 1'b1;
      if (ch_i[3][1]) begin
        clr_o.right = 1'b1;
      end else if (ch_i[1][2]) begin
        clr_o.down_left = 1'b1;
      end else if (ch_i[2][2]) begin
        clr_o.down = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bsnf_back.sv */
// Back end: column line store, 5x4 pixel window, judging and result queue.
// Depends on bsnf_pkg and bsnf_judge.
`default_nettype none

module bsnf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       flush_i,
  input  logic                       q_empty_i,
  input  bsnf_pkg::entry_t           q_head_i,
  output logic                       q_pop_o,
  input  logic [bsnf_pkg::PIX_W-1:0] char_i,
  input  logic [bsnf_pkg::PIX_W-1:0] back_i,
  input  logic                       strict_i,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [bsnf_pkg::PIX_W-1:0] out_pixel_o,
  output logic                       last_pixel_o
);
  import bsnf_pkg::*;

  // line store: one word per column, four ring rows side by side
  logic [WORD_W-1:0] line_mem [MAX_WIDTH];
  logic [WORD_W-1:0] rd_q, wb_word;
  logic              mem_we;
  logic [COL_W-1:0]  wa;

  // step sequencer
  logic [DRAIN_W-1:0] drain_q;
  entry_t             dr_q, a_step, b_q;
  logic               b_drain_q, b_valid_q;
  logic               a_valid, a_drain, a_go, b_go;

  // window: x is column j-2+x, y is row r-3+y
  logic [WIN_COLS-1:0][WIN_ROWS-1:0][PIX_W-1:0] win_pix_q, sh_pix, nx_pix;
  logic [WIN_COLS-1:0][COL_W-1:0]               win_col_q, sh_col;
  logic [WIN_COLS-1:0]                          win_vld_q, sh_vld, win_lastc_q, sh_lastc;
  logic [WIN_COLS-1:0][WIN_ROWS-1:0]            ch;
  logic [SLOT_W-1:0]                            sidx [WIN_ROWS];
  clr_t                                         clr;
  logic                                         judge_en;
  logic [PIX_W-1:0]                             res_pix;

  // result queue
  logic [PIX_W-1:0]  oq_pix_q [QUEUE_DEPTH];
  logic              oq_last_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] oq_wr_q, oq_rd_q;
  logic [QPTR_W:0]   oq_cnt_q;
  logic              oq_full, oq_push, oq_pop;

  assign oq_full = oq_cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = oq_cnt_q == '0;
  assign oq_pop  = pop_i && !empty_o;

  assign a_drain = drain_q != '0;
  assign a_valid = a_drain || !q_empty_i;
  assign b_go    = b_valid_q && !oq_full && !flush_i;
  assign a_go    = a_valid && (!b_valid_q || b_go) && !flush_i;
  assign q_pop_o = a_go && !a_drain;

  always_comb begin
    a_step = q_head_i;
    if (a_drain) begin
      a_step         = dr_q;
      a_step.row_end = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q   <= '0;
      b_valid_q <= 1'b0;
    end else if (flush_i) begin
      drain_q   <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_go) begin
        b_valid_q <= 1'b1;
        if (a_drain) begin
          drain_q <= drain_q - DRAIN_W'(1);
        end else if (q_head_i.row_end) begin
          drain_q <= DRAIN_W'(DRAIN_STEPS);
        end
      end else if (b_go) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      b_q       <= a_step;
      b_drain_q <= a_drain;
      if (!a_drain) begin
        dr_q <= q_head_i;
      end
    end
  end

  // new column enters at x = 4, stored rows come out of ring order
  always_comb begin
    for (int y = 0; y < WIN_ROWS; y++) begin
      sidx[y] = b_q.slot + SLOT_W'(y + 1);
    end
    for (int x = 0; x < WIN_COLS - 1; x++) begin
      sh_pix[x]   = win_pix_q[x+1];
      sh_col[x]   = win_col_q[x+1];
      sh_vld[x]   = win_vld_q[x+1];
      sh_lastc[x] = win_lastc_q[x+1];
    end
    for (int y = 0; y < WIN_ROWS - 1; y++) begin
      sh_pix[WIN_COLS-1][y] = b_q.rin[y] ? rd_q[{sidx[y], 3'b000} +: PIX_W] : back_i;
    end
    sh_pix[WIN_COLS-1][WIN_ROWS-1] = b_q.pix;
    sh_col[WIN_COLS-1]   = b_q.col;
    sh_vld[WIN_COLS-1]   = !b_drain_q;
    sh_lastc[WIN_COLS-1] = b_q.row_end && !b_drain_q;
    for (int x = 0; x < WIN_COLS; x++) begin
      for (int y = 0; y < WIN_ROWS; y++) begin
        ch[x][y] = sh_vld[x] ? (sh_pix[x][y] == char_i) : (back_i == char_i);
      end
    end
  end

  bsnf_judge u_judge (
    .ch_i     (ch),
    .strict_i (strict_i),
    .clr_o    (clr)
  );

  assign judge_en = b_q.judge_row && sh_vld[2];

  always_comb begin
    nx_pix = sh_pix;
    if (judge_en) begin
      if (clr.ctr)       nx_pix[2][1] = back_i;
      if (clr.right)     nx_pix[3][1] = back_i;
      if (clr.down_left) nx_pix[1][2] = back_i;
      if (clr.down)      nx_pix[2][2] = back_i;
    end
    res_pix = nx_pix[2][1];
  end

  // the column leaving the window is final for this row
  always_comb begin
    wb_word = '0;
    for (int y = 0; y < WIN_ROWS; y++) begin
      wb_word[{sidx[y], 3'b000} +: PIX_W] = win_pix_q[0][y];
    end
  end

  assign mem_we = b_go && win_vld_q[0];
  assign wa     = win_col_q[0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[wa] <= wb_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      if (mem_we && wa == q_head_i.col) begin
        rd_q <= wb_word;
      end else begin
        rd_q <= line_mem[q_head_i.col];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go) begin
      win_pix_q   <= nx_pix;
      win_col_q   <= sh_col;
      win_lastc_q <= sh_lastc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q <= '0;
    end else if (flush_i) begin
      win_vld_q <= '0;
    end else if (b_go) begin
      win_vld_q <= sh_vld;
    end
  end

  assign oq_push = b_go && judge_en;

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_pix_q[oq_wr_q]  <= res_pix;
      oq_last_q[oq_wr_q] <= b_q.last_row && sh_lastc[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= oq_wr_q + QPTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + QPTR_W'(1);
      end
      oq_cnt_q <= oq_cnt_q + (QPTR_W+1)'(oq_push) - (QPTR_W+1)'(oq_pop);
    end
  end

  assign out_pixel_o  = oq_pix_q[oq_rd_q];
  assign last_pixel_o = oq_last_q[oq_rd_q];

endmodule

`default_nettype wire

/* rtl/core/binary_speckle_noise_filter.sv */
// Top level of the binary speckle noise filter: configuration registers,
// front end, word queue and back end. Depends on bsnf_pkg, bsnf_front, bsnf_queue and bsnf_back.
//
//   channel   direction  handshake          payload
//   input     in         push / full        op_i, pixel_value_i
//   result    out        empty / pop        out_pixel_o, last_pixel_o
//   config    in         cfg_we_i           cfg_idx_i, cfg_data_i
//
// One input word per cycle while the word queue is not full; each row of W words takes W back-end
// steps plus five drain steps that move the 5x4 window back into the line store.
// An accepted input word passes through the word queue and the back-end step
// register; the result words it causes enter the result queue from that register.
// Reset is asynchronous; the line store is not cleared, every read entry is
// written earlier in the same image. Either side may stall at any time.
// A write to the width or height register restarts the image.
`default_nettype none

module binary_speckle_noise_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            op_i,
  input  logic [bsnf_pkg::PIX_W-1:0]      pixel_value_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [bsnf_pkg::PIX_W-1:0]      out_pixel_o,
  output logic                            last_pixel_o,
  input  logic                            cfg_we_i,
  input  logic [bsnf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bsnf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bsnf_pkg::*;

  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  logic [PIX_W-1:0] char_q, back_q;
  logic             strict_q;
  logic             restart, accept, q_empty, q_pop;
  entry_t           entry, q_head;

  assign restart = cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT);
  assign accept  = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WID_W'(MAX_WIDTH);
      height_q <= HGT_W'(1);
      char_q   <= '0;
      back_q   <= '1;
      strict_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i[WID_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[HGT_W-1:0];
        REG_CHAR:   char_q   <= cfg_data_i[PIX_W-1:0];
        REG_BACK:   back_q   <= cfg_data_i[PIX_W-1:0];
        REG_STRICT: strict_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  bsnf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (restart),
    .accept_i      (accept),
    .op_i          (op_i),
    .pixel_value_i (pixel_value_i),
    .width_i       (width_q),
    .height_i      (height_q),
    .back_i        (back_q),
    .entry_o       (entry)
  );

  bsnf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (restart),
    .push_i  (accept),
    .data_i  (entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  bsnf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flush_i      (restart),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .char_i       (char_q),
    .back_i       (back_q),
    .strict_i     (strict_q),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_pixel_o  (out_pixel_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

`default_nettype wire

/* rtl/core/bsnf_checker.sv */
// Port-level checks on the speckle filter and the bind that attaches them.
// Depends on bsnf_pkg and binary_speckle_noise_filter.
`default_nettype none

module bsnf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            push,
  input logic                            full,
  input logic                            op_i,
  input logic [bsnf_pkg::PIX_W-1:0]      pixel_value_i,
  input logic                            empty,
  input logic                            pop,
  input logic [bsnf_pkg::PIX_W-1:0]      out_pixel_o,
  input logic                            last_pixel_o,
  input logic                            cfg_we_i,
  input logic [bsnf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [bsnf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bsnf_pkg::*;

  // a waiting word stays until popped
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result word withdrawn before pop");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(out_pixel_o) && $stable(last_pixel_o)))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> empty)
    else $error("result present right after reset");

  // a size write restarts the image, nothing in flight may surface
  a_restart_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT) && empty)
    |=> empty)
    else $error("result appeared after image restart");

endmodule

bind binary_speckle_noise_filter bsnf_checker u_bsnf_checker (.*);

`default_nettype wire

/* tb/sv/testbench.sv */
// Testbench of binary_speckle_noise_filter: streams small band images with random
// character pixels and compares every result word with an in-bench filter model.
// Depends on bsnf_pkg and the rtl/core modules.
`default_nettype none

class speckle_board;
  int unsigned width_reg, height_reg, char_val, back_val, strict_on;
  byte unsigned rows[4*bsnf_pkg::MAX_WIDTH];
  int row_n, col_n;
  bit [8:0] pending[$];   // {last_pixel, out_pixel}
  int errors;

  function new();
    width_reg = 1024; height_reg = 1; char_val = 0; back_val = 255; strict_on = 0;
    row_n = 0; col_n = 0; errors = 0;
  endfunction

  function void set_reg(bsnf_pkg::cfg_reg_e idx, int unsigned v);
    case (idx)
      bsnf_pkg::REG_WIDTH: begin
        width_reg = v & 'h7ff; row_n = 0; col_n = 0;
      end
      bsnf_pkg::REG_HEIGHT: begin
        height_reg = v & 'h1fff; row_n = 0; col_n = 0;
      end
      bsnf_pkg::REG_CHAR:   char_val = v & 'hff;
      bsnf_pkg::REG_BACK:   back_val = v & 'hff;
      bsnf_pkg::REG_STRICT: strict_on = v & 1;
      default: ;
    endcase
  endfunction

  function int w_eff();
    if (width_reg == 0) return 1;
    if (width_reg > bsnf_pkg::MAX_WIDTH) return bsnf_pkg::MAX_WIDTH;
    return width_reg;
  endfunction

  function int h_eff();
    if (height_reg == 0) return 1;
    if (height_reg > bsnf_pkg::HEIGHT_LIMIT) return bsnf_pkg::HEIGHT_LIMIT;
    return height_reg;
  endfunction

  function bit in_img(int r, int c);
    return r >= 0 && c >= 0 && r < h_eff() && c < w_eff();
  endfunction

  function int addr(int r, int c);
    return (r % 4) * bsnf_pkg::MAX_WIDTH + c;
  endfunction

  function int unsigned pix(int r, int c);
    if (!in_img(r, c)) return back_val;
    return rows[addr(r, c)];
  endfunction

  function int ch(int r, int c);
    return (pix(r, c) == char_val) ? 1 : 0;
  endfunction

  function void wipe(int r, int c);
    if (in_img(r, c)) rows[addr(r, c)] = back_val;
  endfunction

  function int hrun(int r, int c, int n);
    int s;
    s = 0;
    for (int k = 0; k < n; k++) s += ch(r, c + k);
    return s;
  endfunction

  function int vrun(int r, int c, int n);
    int s;
    s = 0;
    for (int k = 0; k < n; k++) s += ch(r + k, c);
    return s;
  endfunction

  // decide one pixel, possibly clearing a small cluster around it
  function void despeckle(int i, int j);
    int n;
    if (ch(i, j) == 0) return;
    n = ch(i-1, j-1) + ch(i-1, j+1) + ch(i+1, j+1) + ch(i+1, j-1);
    if (n > 2) return;
    if (n < 2) begin
      n += ch(i-1, j) + ch(i, j-1) + ch(i+1, j) + ch(i, j+1);
      if (n == 0) begin
        wipe(i, j);
        return;
      end
      if (n > 1 || strict_on == 0) return;
      n = hrun(i-1, j-2, 4) + hrun(i+1, j-2, 4) + ch(i, j-2) + ch(i, j+1);
      if (n > 1) return;
      n = vrun(i-1, j-1, 4) + vrun(i-1, j+1, 4) + ch(i-1, j) + ch(i+2, j);
      if (n > 1) return;
      n = hrun(i-1, j-1, 4) + hrun(i+1, j-1, 4) + ch(i, j-1) + ch(i, j+2);
      if (n > 1) return;
    end
    n = hrun(i-1, j-1, 4) + hrun(i+2, j-1, 4);
    if (n > 1) return;
    n += vrun(i, j-1, 2) + vrun(i, j+2, 2);
    if (n > 1) return;
    n = hrun(i-1, j-2, 4) + hrun(i+2, j-2, 4);
    if (n > 1) return;
    n += vrun(i, j-2, 2) + vrun(i, j+1, 2);
    if (n >= 2) return;
    wipe(i, j);
    if (ch(i, j+1) != 0) wipe(i, j+1);
    else if (ch(i+1, j-1) != 0) wipe(i+1, j-1);
    else if (ch(i+1, j) != 0) wipe(i+1, j);
  endfunction

  function void note_input(bit op, byte unsigned v);
    int w, h, lo, hi;
    bit fin, done;
    int unsigned p;
    bit [8:0] e;
    w = w_eff(); h = h_eff(); done = 0;
    if (row_n < h) rows[addr(row_n, col_n)] = op ? back_val[7:0] : v;
    if (row_n >= 2) begin
      lo = col_n - 2; hi = col_n - 2;
      if (col_n == w - 1) begin
        hi = col_n;
        if (lo < 0) lo = 0;
      end
      for (int j = lo; j <= hi; j++) begin
        if (j >= 0) begin
          despeckle(row_n - 2, j);
          fin = (row_n - 2 == h - 1) && (j == w - 1);
          p = pix(row_n - 2, j);
          e = {fin, p[7:0]};
          pending = {pending, e};
          if (fin) done = 1;
        end
      end
    end
    if (done) begin
      row_n = 0; col_n = 0;
    end else begin
      col_n++;
      if (col_n >= w) begin
        col_n = 0; row_n++;
      end
    end
  endfunction

  function void check_result(byte unsigned p, bit last);
    bit [8:0] e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected word pixel=%0d last=%0b", $time, p, last);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e[7:0] != p) begin
      $display("%0t: out_pixel expected %0d actual %0d", $time, e[7:0], p);
      errors++;
    end
    if (e[8] != last) begin
      $display("%0t: last_pixel expected %0b actual %0b", $time, e[8], last);
      errors++;
    end
  endfunction
endclass

module testbench;
  import bsnf_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic push = 0, op_i = 0, pop = 0, cfg_we_i = 0;
  logic [PIX_W-1:0] pixel_value_i = '0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic full, empty, last_pixel_o;
  logic [PIX_W-1:0] out_pixel_o;

  speckle_board sb = new();
  int idle_pct = 0, stall_pct = 0, sent = 0;

  binary_speckle_noise_filter u_top (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) pop <= ($urandom_range(99) >= stall_pct);

  // outputs settle before the falling edge; the word moves at the next rising edge
  always @(negedge clk_i) if (rst_ni && pop && !empty) sb.check_result(out_pixel_o, last_pixel_o);

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_word(bit op, byte unsigned v);
    if ($urandom_range(99) < idle_pct) begin
      push <= 0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    push <= 1; op_i <= op; pixel_value_i <= v;
    forever begin
      @(negedge clk_i);
      if (!full) break;
    end
    @(posedge clk_i);
    sb.note_input(op, v);
    sent++;
  endtask

  task automatic wait_idle();
    push <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * MAX_WIDTH + 40) @(posedge clk_i);
  endtask

  task automatic write_regs(int unsigned w, int unsigned h, int unsigned c, int unsigned b,
                            int unsigned s);
    int unsigned vals[5];
    vals = '{w, h, c, b, s};
    for (int k = 0; k < 5; k++) begin
      cfg_we_i <= 1; cfg_idx_i <= CFG_IDX_W'(k); cfg_data_i <= CFG_DATA_W'(vals[k]);
      @(posedge clk_i);
      sb.set_reg(cfg_reg_e'(k), vals[k]);
    end
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  // one whole image, density in percent of character pixels
  task automatic send_image(int unsigned w, int unsigned h, int unsigned c, int unsigned b,
                            int unsigned s, int dens);
    int total, rnd;
    byte unsigned v;
    wait_idle();
    write_regs(w, h, c, b, s);
    total = (sb.h_eff() + 2) * sb.w_eff();
    for (int k = 0; k < total; k++) begin
      rnd = $urandom_range(99);
      if (rnd < dens) v = 8'(c);
      else if (rnd < dens + 10) v = 8'($urandom_range(255));
      else v = 8'(b);
      send_word($urandom_range(99) < 5, v);
    end
  endtask

  initial begin
    int pct[4][2];
    int cv, bv;
    pct = '{'{0, 0}, '{79, 0}, '{0, 79}, '{21, 21}};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: smallest and zero sizes, equal colors, strict mode
    send_image(1, 1, 0, 255, 0, 60);
    send_image(0, 0, 255, 0, 1, 60);
    send_image(2, 1, 0, 255, 1, 40);
    send_image(3, 2, 0, 255, 1, 30);
    send_image(4, 3, 9, 9, 0, 30);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pct[ph][0]; stall_pct = pct[ph][1];
      sent = 0;
      while (sent < 40) begin
        cv = $urandom_range(255);
        bv = ($urandom_range(9) == 0) ? cv : $urandom_range(255);
        send_image($urandom_range(1, 6), $urandom_range(1, 4), cv, bv, $urandom_range(1),
                   $urandom_range(15, 50));
      end
    end
    idle_pct = 0; stall_pct = 0;
    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* files.f */
rtl/core/bsnf_pkg.sv
rtl/core/bsnf_front.sv
rtl/core/bsnf_queue.sv
rtl/core/bsnf_judge.sv
rtl/core/bsnf_back.sv
rtl/core/binary_speckle_noise_filter.sv
rtl/core/bsnf_checker.sv
tb/sv/testbench.sv
